### hdl/alc_pkg.sv
`default_nettype none

package alc_pkg;

    // lane count of both source vectors and of both results
    localparam int LANES = 4;
    // width of a lane count that can hold LANES itself
    localparam int CNT_W = $clog2(LANES + 1);
    // width of a lane index
    localparam int IDX_W = $clog2(LANES);

    typedef logic [LANES-1:0] t_pred;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [IDX_W-1:0] t_idx;

endpackage

`default_nettype wire

### hdl/active_lane_consolidate_core.sv
`default_nettype none

// Active lane consolidation of two four-lane vectors. A transaction is taken on
// every cycle in which start is high; busy never rises, so one transaction per
// cycle is sustained. The result appears on the o_ ports once its transaction
// has passed the input register and then the result register, with the
// consolidation logic between them, and is marked by o_valid for exactly one
// cycle. The receiver cannot stall the block and must take every result as it
// comes. o_packed_lane* holds A's active lanes, then B's active lanes, then
// all-ones fill; o_rest_lane* holds A's inactive lanes, then the sequence of
// B's active and inactive lanes from the lane where A's inactive lanes end.
module active_lane_consolidate_core #(
    parameter int LANE_BITS = 32
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        start,
    output logic                       busy,
    input  wire signed [LANE_BITS-1:0] i_vec_a_lane0,
    input  wire signed [LANE_BITS-1:0] i_vec_a_lane1,
    input  wire signed [LANE_BITS-1:0] i_vec_a_lane2,
    input  wire signed [LANE_BITS-1:0] i_vec_a_lane3,
    input  wire signed [LANE_BITS-1:0] i_vec_b_lane0,
    input  wire signed [LANE_BITS-1:0] i_vec_b_lane1,
    input  wire signed [LANE_BITS-1:0] i_vec_b_lane2,
    input  wire signed [LANE_BITS-1:0] i_vec_b_lane3,
    input  wire alc_pkg::t_pred        i_mask_a,
    input  wire alc_pkg::t_pred        i_mask_b,
    output logic                       o_valid,
    output logic signed [LANE_BITS-1:0] o_packed_lane0,
    output logic signed [LANE_BITS-1:0] o_packed_lane1,
    output logic signed [LANE_BITS-1:0] o_packed_lane2,
    output logic signed [LANE_BITS-1:0] o_packed_lane3,
    output logic signed [LANE_BITS-1:0] o_rest_lane0,
    output logic signed [LANE_BITS-1:0] o_rest_lane1,
    output logic signed [LANE_BITS-1:0] o_rest_lane2,
    output logic signed [LANE_BITS-1:0] o_rest_lane3
);

    import alc_pkg::*;

    typedef logic [LANE_BITS-1:0] t_lane;
    typedef t_lane [LANES-1:0]    t_vec;

    // input register
    logic  r_in_valid;
    t_vec  r_vec_a;
    t_vec  r_vec_b;
    t_pred r_mask_a;
    t_pred r_mask_b;

    // result register
    logic  r_out_valid;
    t_vec  r_packed;
    t_vec  r_rest;
    t_vec  n_packed;
    t_vec  n_rest;

    // the block takes a transaction every cycle
    assign busy = 1'b0;

    // input valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    // input payload
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_vec_a  <= {i_vec_a_lane3, i_vec_a_lane2, i_vec_a_lane1, i_vec_a_lane0};
            r_vec_b  <= {i_vec_b_lane3, i_vec_b_lane2, i_vec_b_lane1, i_vec_b_lane0};
            r_mask_a <= i_mask_a;
            r_mask_b <= i_mask_b;
        end
    end

    // consolidation: every source lane knows its slot from a prefix count
    always_comb begin
        t_cnt na;
        t_cnt nb;
        t_cnt k;
        t_cnt act_a;
        t_cnt ina_a;
        t_cnt act_b;
        t_cnt ina_b;
        t_cnt slot;
        t_vec a_ina;
        t_vec bseq;

        na = '0;
        nb = '0;
        for (int i = 0; i < LANES; i++) begin
            na = na + t_cnt'(r_mask_a[i]);
            nb = nb + t_cnt'(r_mask_b[i]);
        end
        k = t_cnt'(LANES) - na;

        n_packed = '1;
        a_ina    = '0;
        bseq     = '0;
        act_a    = '0;
        ina_a    = '0;
        act_b    = '0;
        ina_b    = '0;
        for (int i = 0; i < LANES; i++) begin
            // lanes of A
            if (r_mask_a[i]) begin
                n_packed[act_a[IDX_W-1:0]] = r_vec_a[i];
                act_a = act_a + t_cnt'(1);
            end else begin
                a_ina[ina_a[IDX_W-1:0]] = r_vec_a[i];
                ina_a = ina_a + t_cnt'(1);
            end
            // lanes of B: packed slot after A's actives, sequence slot after B's actives
            if (r_mask_b[i]) begin
                slot = na + act_b;
                if (slot < t_cnt'(LANES)) begin
                    n_packed[slot[IDX_W-1:0]] = r_vec_b[i];
                end
                bseq[act_b[IDX_W-1:0]] = r_vec_b[i];
                act_b = act_b + t_cnt'(1);
            end else begin
                slot = nb + ina_b;
                bseq[slot[IDX_W-1:0]] = r_vec_b[i];
                ina_b = ina_b + t_cnt'(1);
            end
        end

        // rest: A's inactive lanes below k, the B sequence from k on
        for (int j = 0; j < LANES; j++) begin
            n_rest[j] = (t_cnt'(j) < k) ? a_ina[j] : bseq[j];
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_packed <= n_packed;
            r_rest   <= n_rest;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_packed_lane0 = r_packed[0];
    assign o_packed_lane1 = r_packed[1];
    assign o_packed_lane2 = r_packed[2];
    assign o_packed_lane3 = r_packed[3];
    assign o_rest_lane0   = r_rest[0];
    assign o_rest_lane1   = r_rest[1];
    assign o_rest_lane2   = r_rest[2];
    assign o_rest_lane3   = r_rest[3];

    // every result comes from a transaction held in the input register
    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $past(r_in_valid))
        else $error("result without a transaction");

    // with no active lane anywhere the first and last packed lanes are all fill
    a_all_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && ($past(r_mask_a) == '0) && ($past(r_mask_b) == '0)
            |-> (&r_packed[0]) && (&r_packed[LANES-1]))
        else $error("packed vector not filled");

    // with A fully inactive the first and last rest lanes are A's lanes unchanged
    a_rest_is_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && ($past(r_mask_a) == '0)
            |-> (r_rest[0] == $past(r_vec_a[0])) && (r_rest[LANES-1] == $past(r_vec_a[LANES-1])))
        else $error("rest vector does not match inactive A");

    // with A fully active the first and last packed lanes are A's lanes unchanged
    a_packed_is_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && ($past(r_mask_a) == '1)
            |-> (r_packed[0] == $past(r_vec_a[0])) && (r_packed[LANES-1] == $past(r_vec_a[LANES-1])))
        else $error("packed vector does not match active A");

endmodule

`default_nettype wire
